// ===== rtl/lcar_pkg.sv =====
// ----------------------------------------------------------------------------
// Load cell reader package
// Field widths, codes, reset values and shared types of the load cell reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

  // Default sample format.
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int EXTRA_PULSES_DEF = 1;

  // Field widths.
  localparam int KIND_W     = 2;
  localparam int SAMPLES_W  = 8;
  localparam int SCALE_W    = 32;
  localparam int TIMEOUT_W  = 20;
  localparam int UNITS_W    = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TARE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

  // Register reset values.
  localparam logic signed [SCALE_W-1:0] SCALE_RESET   = 32'sd65536;
  localparam logic [TIMEOUT_W-1:0]      TIMEOUT_RESET = 20'd100;

  // Status of one readout step, as it stands after the step.
  typedef struct packed {
    logic sck;
    logic busy;
    logic done;
    logic ok;
    logic calc_start;
  } readout_status_t;

endpackage

// ===== rtl/lcar_if.sv =====
// ----------------------------------------------------------------------------
// Load cell reader channels
// Valid/ready channels for tick and request items, results and configuration.
// ----------------------------------------------------------------------------
interface lcar_in_if;
  import lcar_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [SAMPLES_W-1:0] samples;
  logic                 dout_level;

  modport source (output valid, kind, samples, dout_level, input ready);
  modport sink   (input valid, kind, samples, dout_level, output ready);
endinterface

interface lcar_out_if;
  import lcar_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      sck_level;
  logic                      busy_res;
  logic                      done_res;
  logic                      ok;
  logic signed [UNITS_W-1:0] units;
  logic                      have_value;

  modport source (output valid, sck_level, busy_res, done_res, ok, units, have_value,
                  input ready);
  modport sink   (input valid, sck_level, busy_res, done_res, ok, units, have_value,
                  output ready);
endinterface

interface lcar_cfg_if;
  import lcar_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lcar_readout.sv =====
// ----------------------------------------------------------------------------
// Load cell reader serial readout
// Pin sequencer: waits for data ready, clocks the sample in and sums samples.
// ----------------------------------------------------------------------------
module lcar_readout #(
  parameter int  SAMPLE_BITS  = lcar_pkg::SAMPLE_BITS_DEF,
  parameter int  EXTRA_PULSES = lcar_pkg::EXTRA_PULSES_DEF,
  localparam int SumW         = SAMPLE_BITS + lcar_pkg::SAMPLES_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_i,
  input  logic [lcar_pkg::KIND_W-1:0]       kind_i,
  input  logic [lcar_pkg::SAMPLES_W-1:0]    samples_i,
  input  logic                              dout_i,
  input  logic [lcar_pkg::TIMEOUT_W-1:0]    timeout_i,
  output lcar_pkg::readout_status_t         status_o,
  output logic signed [SumW-1:0]            sum_o,
  output logic [lcar_pkg::SAMPLES_W-1:0]    count_o,
  output logic                              tare_o
);
  import lcar_pkg::*;

  localparam int TotalPulses = SAMPLE_BITS + EXTRA_PULSES;
  localparam int PulseW      = $clog2(TotalPulses + 1);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [PulseW-1:0]       pulse_r, pulse_nxt;
  logic [SAMPLE_BITS-1:0]  shift_r, shift_nxt;
  logic signed [SumW-1:0]  sum_r, sum_nxt;
  logic [SAMPLES_W-1:0]    taken_r, taken_nxt;
  logic [SAMPLES_W-1:0]    wanted_r, wanted_nxt;
  logic [TIMEOUT_W-1:0]    wait_r, wait_nxt;
  logic                    tare_r, tare_nxt;
  logic                    clock_r, clock_nxt;
  logic                    check_next;
  logic                    finish;
  logic signed [SumW-1:0]  sample_ext;

  // Sign-extended sample from the shift register.
  assign sample_ext = {{SAMPLES_W{shift_r[SAMPLE_BITS-1]}}, shift_r};

  // Next state for one tick or request item.
  always_comb begin
    phase_nxt  = phase_r;
    pulse_nxt  = pulse_r;
    shift_nxt  = shift_r;
    sum_nxt    = sum_r;
    taken_nxt  = taken_r;
    wanted_nxt = wanted_r;
    wait_nxt   = wait_r;
    tare_nxt   = tare_r;
    clock_nxt  = clock_r;
    check_next = 1'b0;
    finish     = 1'b0;
    case (kind_i)
      KIND_READ, KIND_TARE: begin
        if (phase_r == PH_IDLE) begin
          wanted_nxt = (samples_i != '0) ? samples_i : SAMPLES_W'(1);
          taken_nxt  = '0;
          sum_nxt    = '0;
          wait_nxt   = '0;
          tare_nxt   = (kind_i == KIND_TARE);
          phase_nxt  = PH_WAIT;
        end
      end
      KIND_TICK: begin
        case (phase_r)
          PH_WAIT: begin
            if (!dout_i) begin
              pulse_nxt = '0;
              shift_nxt = '0;
              clock_nxt = 1'b1;
              phase_nxt = PH_HIGH;
            end else begin
              wait_nxt = wait_r + 1'b1;
              if (wait_nxt >= timeout_i) begin
                // A tare counts a missing sample as zero; a read stops here.
                if (tare_r) begin
                  taken_nxt  = taken_r + 1'b1;
                  check_next = 1'b1;
                end else begin
                  finish = 1'b1;
                end
              end
            end
          end
          PH_HIGH: begin
            if (pulse_r < PulseW'(SAMPLE_BITS)) begin
              shift_nxt = {shift_r[SAMPLE_BITS-2:0], dout_i};
            end
            pulse_nxt = pulse_r + 1'b1;
            clock_nxt = 1'b0;
            phase_nxt = PH_LOW;
          end
          PH_LOW: begin
            if (pulse_r < PulseW'(TotalPulses)) begin
              clock_nxt = 1'b1;
              phase_nxt = PH_HIGH;
            end else begin
              sum_nxt    = sum_r + sample_ext;
              taken_nxt  = taken_r + 1'b1;
              check_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // After a sample is counted, wait for the next one or end the request.
    if (check_next) begin
      if (taken_nxt >= wanted_r) begin
        finish = 1'b1;
      end else begin
        phase_nxt = PH_WAIT;
        wait_nxt  = '0;
      end
    end
    if (finish) begin
      phase_nxt = PH_IDLE;
      clock_nxt = 1'b0;
    end
  end

  // Status as it stands after this item.
  always_comb begin
    status_o.sck        = clock_nxt;
    status_o.busy       = (phase_nxt != PH_IDLE);
    status_o.done       = finish;
    status_o.ok         = finish && (taken_nxt != '0);
    status_o.calc_start = finish && (taken_nxt != '0);
  end

  // State registers, advanced once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pulse_r  <= '0;
      shift_r  <= '0;
      sum_r    <= '0;
      taken_r  <= '0;
      wanted_r <= '0;
      wait_r   <= '0;
      tare_r   <= 1'b0;
      clock_r  <= 1'b0;
    end else if (step_i) begin
      phase_r  <= phase_nxt;
      pulse_r  <= pulse_nxt;
      shift_r  <= shift_nxt;
      sum_r    <= sum_nxt;
      taken_r  <= taken_nxt;
      wanted_r <= wanted_nxt;
      wait_r   <= wait_nxt;
      tare_r   <= tare_nxt;
      clock_r  <= clock_nxt;
    end
  end

  assign sum_o   = sum_r;
  assign count_o = taken_r;
  assign tare_o  = tare_r;

endmodule

// ===== rtl/lcar_arith.sv =====
// ----------------------------------------------------------------------------
// Load cell reader arithmetic
// Averages the sum with a shift-subtract divider, then applies offset and
// scale with saturation. Holds the zero offset and the last good weight.
// ----------------------------------------------------------------------------
module lcar_arith #(
  parameter int  SAMPLE_BITS = lcar_pkg::SAMPLE_BITS_DEF,
  localparam int SumW        = SAMPLE_BITS + lcar_pkg::SAMPLES_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic signed [SumW-1:0]              sum_i,
  input  logic [lcar_pkg::SAMPLES_W-1:0]      count_i,
  input  logic                                tare_i,
  input  logic signed [lcar_pkg::SCALE_W-1:0] scale_i,
  output logic                                done_o,
  output logic signed [lcar_pkg::UNITS_W-1:0] units_o,
  output logic                                have_o
);
  import lcar_pkg::*;

  localparam int CntW  = $clog2(SumW);
  localparam int DiffW = SAMPLE_BITS + 1;
  localparam int ProdW = DiffW + SCALE_W;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_DIV  = 5'b00010,
    A_AVG  = 5'b00100,
    A_MUL  = 5'b01000,
    A_SAT  = 5'b10000
  } astate_t;

  astate_t                        state_r;
  logic [CntW-1:0]                cnt_r;
  logic [SAMPLES_W-1:0]           rem_r;
  logic [SumW-1:0]                quo_r;
  logic [SAMPLES_W-1:0]           count_r;
  logic                           neg_r;
  logic                           tare_r;
  logic signed [SAMPLE_BITS-1:0]  avg_r;
  logic signed [SAMPLE_BITS-1:0]  offset_r;
  logic signed [ProdW-1:0]        prod_r;
  logic signed [UNITS_W-1:0]      units_r;
  logic                           have_r;

  logic [SumW-1:0]                sum_mag;
  logic [SAMPLES_W:0]             rem_sh;
  logic                           fits;
  logic [SAMPLES_W:0]             rem_diff;
  logic signed [DiffW-1:0]        diff;
  logic [ProdW-UNITS_W:0]         prod_top;
  logic signed [UNITS_W-1:0]      sat_val;

  assign sum_mag = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);

  // One restoring divide step: shift in the next dividend bit, try subtract.
  assign rem_sh   = {rem_r, quo_r[SumW-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};
  assign fits     = (rem_sh >= {1'b0, count_r});

  // Offset-corrected average.
  assign diff = {avg_r[SAMPLE_BITS-1], avg_r} - {offset_r[SAMPLE_BITS-1], offset_r};

  // Saturate the product to the result range.
  assign prod_top = prod_r[ProdW-1:UNITS_W-1];
  always_comb begin
    if ((prod_top == '0) || (prod_top == '1)) begin
      sat_val = prod_r[UNITS_W-1:0];
    end else if (prod_r[ProdW-1]) begin
      sat_val = {1'b1, {(UNITS_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(UNITS_W-1){1'b1}}};
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= A_IDLE;
      offset_r <= '0;
      units_r  <= '0;
      have_r   <= 1'b0;
    end else begin
      case (state_r)
        A_IDLE: begin
          if (start_i) begin
            state_r <= A_DIV;
          end
        end
        A_DIV: begin
          if (cnt_r == '0) begin
            state_r <= A_AVG;
          end
        end
        A_AVG: begin
          state_r <= A_MUL;
        end
        A_MUL: begin
          if (tare_r) begin
            offset_r <= avg_r;
            state_r  <= A_IDLE;
          end else begin
            state_r <= A_SAT;
          end
        end
        A_SAT: begin
          units_r <= sat_val;
          have_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (start_i) begin
          quo_r   <= sum_mag;
          rem_r   <= '0;
          cnt_r   <= CntW'(SumW - 1);
          count_r <= count_i;
          neg_r   <= sum_i[SumW-1];
          tare_r  <= tare_i;
        end
      end
      A_DIV: begin
        rem_r <= fits ? rem_diff[SAMPLES_W-1:0] : rem_sh[SAMPLES_W-1:0];
        quo_r <= {quo_r[SumW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
      end
      A_AVG: begin
        // Truncation toward zero: divide magnitudes, then restore the sign.
        avg_r <= neg_r ? SAMPLE_BITS'(-quo_r[SAMPLE_BITS-1:0]) : quo_r[SAMPLE_BITS-1:0];
      end
      A_MUL: begin
        prod_r <= diff * scale_i;
      end
      default: ;
    endcase
  end

  assign done_o  = ((state_r == A_MUL) && tare_r) || (state_r == A_SAT);
  assign units_o = units_r;
  assign have_o  = have_r;

endmodule

// ===== rtl/load_cell_adc_reader.sv =====
// ----------------------------------------------------------------------------
// Load cell converter reader
// Serial readout of a bridge converter with averaging, tare and scaling.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result transaction. A tick or request
// that does not end a request with samples has its result ready in the
// output register on the next cycle. The item that ends a request with at
// least one sample starts the shared arithmetic sequencer: a one-bit-per-cycle
// restoring divider over SAMPLE_BITS+8 bits, then the sign fix, the offset
// multiply and the saturation. A tare skips the saturation. The input is not
// ready meanwhile. The units and have_value fields show the last good weight
// held in the arithmetic unit. Configuration writes are taken in any cycle
// out of reset and must only be issued when the block is idle.
module load_cell_adc_reader #(
  parameter int SAMPLE_BITS  = lcar_pkg::SAMPLE_BITS_DEF,
  parameter int EXTRA_PULSES = lcar_pkg::EXTRA_PULSES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lcar_in_if.sink   in_ch,
  lcar_out_if.source out_ch,
  lcar_cfg_if.sink  cfg_ch
);
  import lcar_pkg::*;

  localparam int SumW = SAMPLE_BITS + SAMPLES_W;

  logic signed [SCALE_W-1:0] scale_r;
  logic [TIMEOUT_W-1:0]      timeout_r;
  logic                      accept;
  logic                      pending_r;
  logic                      start_r;
  logic                      out_valid_r;
  readout_status_t           status;
  readout_status_t           hold_r;
  logic signed [SumW-1:0]    sum;
  logic [SAMPLES_W-1:0]      count;
  logic                      tare;
  logic                      calc_done;
  logic signed [UNITS_W-1:0] units;
  logic                      have;

  // Input handshake: out of reset, free output slot and no calculation in flight.
  assign in_ch.ready = rst_n && !pending_r && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration registers.
  assign cfg_ch.ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_SCALE:   scale_r   <= cfg_ch.data[SCALE_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_ch.data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  lcar_readout #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .EXTRA_PULSES (EXTRA_PULSES)
  ) u_readout (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (accept),
    .kind_i    (in_ch.kind),
    .samples_i (in_ch.samples),
    .dout_i    (in_ch.dout_level),
    .timeout_i (timeout_r),
    .status_o  (status),
    .sum_o     (sum),
    .count_o   (count),
    .tare_o    (tare)
  );

  lcar_arith #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start_r),
    .sum_i   (sum),
    .count_i (count),
    .tare_i  (tare),
    .scale_i (scale_r),
    .done_o  (calc_done),
    .units_o (units),
    .have_o  (have)
  );

  // Output register; a finishing request waits for the arithmetic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pending_r   <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      start_r <= accept && status.calc_start;
      if (accept) begin
        out_valid_r <= !status.calc_start;
        pending_r   <= status.calc_start;
      end else if (pending_r && calc_done) begin
        out_valid_r <= 1'b1;
        pending_r   <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sck_level  = hold_r.sck;
  assign out_ch.busy_res   = hold_r.busy;
  assign out_ch.done_res   = hold_r.done;
  assign out_ch.ok         = hold_r.ok;
  assign out_ch.units      = units;
  assign out_ch.have_value = have;

endmodule

// ===== rtl/lcar_checker.sv =====
// ----------------------------------------------------------------------------
// Load cell reader checker
// Port-level assertions on the load cell reader, bound to the top level.
// ----------------------------------------------------------------------------
module lcar_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                sck_level,
  input logic                                busy_res,
  input logic                                done_res,
  input logic                                ok,
  input logic signed [lcar_pkg::UNITS_W-1:0] units,
  input logic                                have_value
);

  // Success is only reported on the result that finishes a request.
  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ok |-> done_res)
    else $error("ok set on a result without done");

  // A finished request leaves the block idle with the clock pin low.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res && !sck_level)
    else $error("done result shows busy or clock high");

  // A waiting result blocks new input transactions.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while a result is stalled");

  // The value-ready flag never drops once set.
  a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(have_value))
    else $error("have_value dropped");

  // A stalled result keeps its weight.
  a_units_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(units))
    else $error("stalled result changed");

endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sck_level  (out_ch.sck_level),
  .busy_res   (out_ch.busy_res),
  .done_res   (out_ch.done_res),
  .ok         (out_ch.ok),
  .units      (out_ch.units),
  .have_value (out_ch.have_value)
);

// ===== tb/sv/load_cell_adc_reader_test.sv =====
// ----------------------------------------------------------------------------
// Load cell reader testbench
// Drives tick, read and tare transactions into the reader and predicts every
// status transaction from its own model of the serial readout, averaging,
// tare and fixed-point scaling. Directed tests cover idle items, timeouts,
// truncating averages, saturation and a long average; random traffic follows
// the readout phases. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_test;
  import lcar_pkg::*;

  localparam int SAMPLE_BITS     = SAMPLE_BITS_DEF;
  localparam int EXTRA_PULSES    = EXTRA_PULSES_DEF;
  localparam int IDLE_PCT        = 18;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int END_CYCLES      = 60;
  localparam int DRAIN_LIMIT     = 50000;

  // Kind code that the block ignores.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef enum logic [3:0] {
    RD_IDLE = 4'b0001,
    RD_WAIT = 4'b0010,
    RD_HIGH = 4'b0100,
    RD_LOW  = 4'b1000
  } rd_phase_t;

  typedef struct packed {
    logic                      sck;
    logic                      busy;
    logic                      done;
    logic                      ok;
    logic signed [UNITS_W-1:0] units;
    logic                      have;
  } reader_status_t;

  logic clk;
  logic rst_n;

  lcar_in_if  in_ch();
  lcar_out_if out_ch();
  lcar_cfg_if cfg_ch();

  load_cell_adc_reader u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted reader state and registers.
  logic signed [SCALE_W-1:0] m_scale;
  logic [TIMEOUT_W-1:0]      m_timeout;
  rd_phase_t                 m_phase;
  int                        m_pulses;
  logic [SAMPLE_BITS-1:0]    m_shift;
  longint                    m_sum;
  int                        m_taken;
  int                        m_wanted;
  logic [TIMEOUT_W-1:0]      m_wait;
  bit                        m_tare;
  longint                    m_offset;
  logic signed [UNITS_W-1:0] m_units;
  bit                        m_have;
  bit                        m_sck;

  reader_status_t expected_status[$];
  int  mismatches = 0;
  bit  steady = 0;
  int  hold_off_asks = 0;
  int  hold_off_taken = 0;
  int  hold_off_left = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2400000;
    $display("FAIL");
    $finish;
  end

  function automatic void reset_model();
    m_scale   = SCALE_RESET;
    m_timeout = TIMEOUT_RESET;
    m_phase   = RD_IDLE;
    m_pulses  = 0;
    m_shift   = '0;
    m_sum     = 0;
    m_taken   = 0;
    m_wanted  = 0;
    m_wait    = '0;
    m_tare    = 0;
    m_offset  = 0;
    m_units   = '0;
    m_have    = 0;
    m_sck     = 0;
  endfunction

  // Ends a request: averages, then stores the offset or the scaled weight.
  function automatic bit close_request();
    longint avg;
    longint prod;
    longint units_max;
    units_max = (longint'(1) <<< (UNITS_W - 1)) - 1;
    m_phase = RD_IDLE;
    m_sck = 0;
    if (m_taken == 0) return 0;
    avg = m_sum / longint'(m_taken);
    if (m_tare) begin
      m_offset = avg;
      return 1;
    end
    prod = (avg - m_offset) * longint'(m_scale);
    if (prod > units_max) prod = units_max;
    if (prod < -units_max - 1) prod = -units_max - 1;
    m_units = prod[UNITS_W-1:0];
    m_have = 1;
    return 1;
  endfunction

  // After a counted sample: wait for the next one, or end the request.
  function automatic bit advance_after_sample(output bit ok);
    ok = 0;
    if (m_taken >= m_wanted) begin
      ok = close_request();
      return 1;
    end
    m_phase = RD_WAIT;
    m_wait = '0;
    return 0;
  endfunction

  // Predicts the status transaction caused by one input transaction.
  function automatic reader_status_t predict_status(logic [KIND_W-1:0] kind,
                                                    logic [SAMPLES_W-1:0] samples,
                                                    logic dout);
    reader_status_t res;
    bit done;
    bit ok;
    done = 0;
    ok = 0;
    if (kind == KIND_READ || kind == KIND_TARE) begin
      if (m_phase == RD_IDLE) begin
        m_wanted = (samples == 0) ? 1 : int'(samples);
        m_taken  = 0;
        m_sum    = 0;
        m_wait   = '0;
        m_tare   = (kind == KIND_TARE);
        m_phase  = RD_WAIT;
      end
    end else if (kind == KIND_TICK) begin
      case (m_phase)
        RD_WAIT: begin
          if (dout == 1'b0) begin
            m_pulses = 0;
            m_shift  = '0;
            m_sck    = 1;
            m_phase  = RD_HIGH;
          end else begin
            m_wait = m_wait + 1'b1;
            if (m_wait >= m_timeout) begin
              if (m_tare) begin
                // A timed-out tare sample counts as zero.
                m_taken++;
                done = advance_after_sample(ok);
              end else begin
                ok = close_request();
                done = 1;
              end
            end
          end
        end
        RD_HIGH: begin
          if (m_pulses < SAMPLE_BITS) m_shift = {m_shift[SAMPLE_BITS-2:0], dout};
          m_pulses++;
          m_sck = 0;
          m_phase = RD_LOW;
        end
        RD_LOW: begin
          if (m_pulses < SAMPLE_BITS + EXTRA_PULSES) begin
            m_sck = 1;
            m_phase = RD_HIGH;
          end else begin
            m_sum = m_sum + longint'($signed(m_shift));
            m_taken++;
            done = advance_after_sample(ok);
          end
        end
        default: ;
      endcase
    end
    res.sck   = m_sck;
    res.busy  = (m_phase != RD_IDLE);
    res.done  = done;
    res.ok    = done & ok;
    res.units = m_units;
    res.have  = m_have;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic signed [63:0] got,
                               logic signed [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offers one input transaction, with random idle cycles in front of it.
  task automatic offer_item(logic [KIND_W-1:0] kind, logic [SAMPLES_W-1:0] samples,
                            logic dout);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.samples    <= samples;
    in_ch.dout_level <= dout;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_status.push_back(predict_status(kind, samples, dout));
  endtask

  // One full converter sample: not-ready ticks, data ready, then the pulses.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] value, int waits);
    for (int i = 0; i < waits; i++) offer_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
    offer_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'b0);
    for (int p = 0; p < SAMPLE_BITS + EXTRA_PULSES; p++) begin
      offer_item(KIND_TICK, 8'($urandom_range(0, 255)),
                 (p < SAMPLE_BITS) ? value[SAMPLE_BITS-1-p] : 1'($urandom_range(0, 1)));
      offer_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Stops offering and waits until every expected status has arrived.
  task automatic drain_status();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // Runs any open request to its end, then lets the block go idle.
  task automatic quiesce();
    while (m_phase != RD_IDLE) offer_item(KIND_TICK, 8'd0, 1'b0);
    drain_status();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_SCALE) m_scale = value;
    else if (idx == CFG_TIMEOUT) m_timeout = value[TIMEOUT_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] scale, logic [TIMEOUT_W-1:0] timeout);
    quiesce();
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_TIMEOUT, {{(CFG_DATA_W - TIMEOUT_W){1'b0}}, timeout});
  endtask

  // Ticks and the spare kind while idle change nothing.
  task automatic test_idle_items();
    offer_item(KIND_TICK, 8'd0, 1'b0);
    offer_item(KIND_TICK, 8'hFF, 1'b1);
    offer_item(KIND_SPARE, 8'hFF, 1'b1);
    offer_item(KIND_SPARE, 8'd0, 1'b0);
  endtask

  // Single and two-sample reads with the reset registers, with ignored
  // requests arriving while busy.
  task automatic test_basic_reads();
    offer_item(KIND_READ, 8'd0, 1'b1);
    offer_item(KIND_TARE, 8'hFF, 1'b0);
    offer_item(KIND_SPARE, 8'h5A, 1'b0);
    send_sample(24'h7FFFFF, 2);
    offer_item(KIND_READ, 8'd2, 1'b0);
    offer_item(KIND_READ, 8'd7, 1'b1);
    send_sample(24'h000001, 0);
    send_sample(24'h000002, 1);
    offer_item(KIND_READ, 8'd1, 1'b1);
    send_sample(24'h800000, 0);
  endtask

  // Timeouts with the shortest wait: an empty read, an early end, tare
  // samples counted as zero and a negative average truncated toward zero.
  task automatic test_timeouts();
    set_regs(SCALE_RESET, 20'd1);
    offer_item(KIND_READ, 8'd0, 1'b0);
    offer_item(KIND_TICK, 8'd0, 1'b1);
    offer_item(KIND_READ, 8'd3, 1'b0);
    send_sample(24'h123456, 0);
    offer_item(KIND_TICK, 8'd0, 1'b1);
    offer_item(KIND_TARE, 8'd2, 1'b0);
    send_sample(24'hFFFFFD, 0);
    offer_item(KIND_TICK, 8'd0, 1'b1);
    offer_item(KIND_READ, 8'd1, 1'b0);
    send_sample(24'h000000, 0);
    offer_item(KIND_TARE, 8'd2, 1'b0);
    offer_item(KIND_TICK, 8'd0, 1'b1);
    offer_item(KIND_TICK, 8'd0, 1'b1);
  endtask

  // Largest tare count, most negative offset, and saturation both ways.
  task automatic test_extremes();
    offer_item(KIND_TARE, 8'hFF, 1'b0);
    for (int i = 0; i < 255; i++) offer_item(KIND_TICK, 8'd0, 1'b1);
    offer_item(KIND_TARE, 8'd1, 1'b0);
    send_sample(24'h800000, 0);
    set_regs(32'h7FFFFFFF, 20'd1);
    offer_item(KIND_READ, 8'd1, 1'b0);
    send_sample(24'h7FFFFF, 0);
    set_regs(32'h80000000, 20'd1);
    offer_item(KIND_READ, 8'd1, 1'b0);
    send_sample(24'h7FFFFF, 0);
    set_regs(32'h00000000, 20'd1);
    offer_item(KIND_READ, 8'd1, 1'b0);
    send_sample(SAMPLE_BITS'($urandom), 0);
    offer_item(KIND_TARE, 8'd1, 1'b0);
    offer_item(KIND_TICK, 8'd0, 1'b1);
  endtask

  // A multi-sample average with the longest timeout and no idling on
  // either side.
  task automatic test_long_average();
    set_regs(SCALE_RESET, 20'hFFFFF);
    steady = 1;
    offer_item(KIND_READ, 8'd3, 1'b0);
    for (int i = 0; i < 3; i++) send_sample(SAMPLE_BITS'($urandom), $urandom_range(0, 3));
    steady = 0;
    set_regs(SCALE_RESET, TIMEOUT_RESET);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_off_asks++;
    offer_item(KIND_READ, 8'd1, 1'b0);
    send_sample(SAMPLE_BITS'($urandom), 1);
    for (int i = 0; i < 20; i++) offer_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
    drain_status();
  endtask

  // Random traffic shaped by the predicted phase; busy_pct sets how often
  // the data line reads not ready while waiting.
  task automatic random_traffic(int count, int busy_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      case (m_phase)
        RD_IDLE: begin
          if (r < 60)
            offer_item(($urandom_range(0, 99) < 35) ? KIND_TARE : KIND_READ,
                       ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom_range(4, 12)),
                       1'($urandom_range(0, 1)));
          else if (r < 90) offer_item(KIND_TICK, 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
          else offer_item(KIND_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        RD_WAIT: begin
          if (r < 6) offer_item(KIND_W'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
          else offer_item(KIND_TICK, 8'($urandom_range(0, 255)),
                          $urandom_range(0, 99) < busy_pct);
        end
        default: begin
          if (r < 4) offer_item(KIND_W'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
          else offer_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    set_regs($urandom, 20'($urandom_range(1, 6)));
    random_traffic(75, 50);
    set_regs(32'h7FFFFFFF, 20'd1);
    random_traffic(45, 70);
    set_regs(32'h80000000, 20'd3);
    steady = 1;
    random_traffic(60, 50);
    steady = 0;
    set_regs($urandom_range(0, 200000) - 100000,
             ($urandom_range(0, 1) != 0) ? 20'($urandom_range(1, 1048575)) : 20'd2);
    random_traffic(60, 30);
    set_regs($urandom, 20'd8);
    random_traffic(60, 60);
  endtask

  // Result side: ready with random hold-offs, plus the long stretch on request.
  always @(negedge clk) begin
    if (hold_off_asks != hold_off_taken) begin
      hold_off_taken = hold_off_asks;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Each status transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    reader_status_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_status.size() == 0) begin
        report_mismatch("status transaction with no expectation");
      end else begin
        want = expected_status.pop_front();
        compare_field("sck_level", 64'(out_ch.sck_level), 64'(want.sck));
        compare_field("busy_res", 64'(out_ch.busy_res), 64'(want.busy));
        compare_field("done_res", 64'(out_ch.done_res), 64'(want.done));
        compare_field("ok", 64'(out_ch.ok), 64'(want.ok));
        compare_field("units", 64'($signed(out_ch.units)), 64'($signed(want.units)));
        compare_field("have_value", 64'(out_ch.have_value), 64'(want.have));
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_TICK;
    in_ch.samples    = '0;
    in_ch.dout_level = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_SCALE;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_basic_reads();
    test_timeouts();
    test_extremes();
    test_long_average();
    test_backpressure();
    test_random_traffic();

    // Finish open work, then watch for stray transactions.
    while (m_phase != RD_IDLE) offer_item(KIND_TICK, 8'd0, 1'b0);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && expected_status.size() != 0; i++) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d expected status transactions never came",
                                expected_status.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
